// ----- src/mkdb_pkg.sv -----
// ----------------------------------------------------------------------------
// mkdb_pkg
// Shared types and constants for the multi-key debouncer with events.
// ----------------------------------------------------------------------------
`default_nettype none

package mkdb_pkg;

  // Default number of debounced switches.
  localparam int NUM_KEYS_DEF = 8;

  // Width of the switch level field in an item.
  localparam int LEVEL_W = 8;

  // Debounce register reset value.
  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

  // Hold counter saturation value.
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  // Item operation codes.
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_RD_PRESS   = 3'd1,
    MODE_RD_RELEASE = 3'd2,
    MODE_HOLD_QUERY = 3'd3,
    MODE_CLR_FLAGS  = 3'd4
  } mode_t;

  // Per-switch debounce phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_PRESS_DB   = 4'b0010,
    PH_HELD       = 4'b0100,
    PH_RELEASE_DB = 4'b1000
  } phase_t;

  // Commands from the top level to one lane.
  typedef struct packed {
    logic tick;
    logic rd_press;
    logic rd_release;
    logic clr_flags;
  } lane_ctrl_t;

  // What one lane reports to the merging stage.
  typedef struct packed {
    logic        press;
    logic        release_ev;
    logic [15:0] hold;
  } lane_status_t;

endpackage

`default_nettype wire

// ----- src/mkdb_lane.sv -----
// ----------------------------------------------------------------------------
// mkdb_lane
// Debounce machine, hold counter and sticky event flags of one switch.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdb_lane
  import mkdb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire lane_ctrl_t   ctrl,
  input  wire logic         level,
  input  wire logic [7:0]   debounce_ticks,
  output lane_status_t      status
);

  phase_t      phase_r,   phase_nxt;
  logic [7:0]  settle_r,  settle_nxt;
  logic [15:0] hold_r,    hold_nxt;
  logic        press_r,   press_nxt;
  logic        release_r, release_nxt;

  // Next-state logic for a tick, a flag read or a flag clear.
  always_comb begin
    phase_nxt   = phase_r;
    settle_nxt  = settle_r;
    hold_nxt    = hold_r;
    press_nxt   = press_r;
    release_nxt = release_r;

    if (ctrl.tick) begin
      case (phase_r)
        PH_IDLE: begin
          if (level) begin
            settle_nxt = debounce_ticks;
            phase_nxt  = PH_PRESS_DB;
          end
        end
        PH_PRESS_DB: begin
          if (settle_r == 8'd0) begin
            if (level) begin
              press_nxt = 1'b1;
              phase_nxt = PH_HELD;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_HELD: begin
          if (hold_r != HOLD_MAX) hold_nxt = hold_r + 16'd1;
          if (!level) begin
            settle_nxt = debounce_ticks;
            phase_nxt  = PH_RELEASE_DB;
          end
        end
        PH_RELEASE_DB: begin
          if (hold_r != HOLD_MAX) hold_nxt = hold_r + 16'd1;
          if (settle_r == 8'd0) begin
            if (!level) begin
              release_nxt = 1'b1;
              hold_nxt    = 16'd0;
              phase_nxt   = PH_IDLE;
            end else begin
              phase_nxt = PH_HELD;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      // The settle counter runs down after the phase step, also on the load tick.
      if (settle_nxt != 8'd0) settle_nxt = settle_nxt - 8'd1;
    end

    // Flag reads clear the flag they return; a clear drops both.
    if (ctrl.rd_press || ctrl.clr_flags) press_nxt = 1'b0;
    if (ctrl.rd_release || ctrl.clr_flags) release_nxt = 1'b0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      settle_r  <= 8'd0;
      hold_r    <= 16'd0;
      press_r   <= 1'b0;
      release_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      settle_r  <= settle_nxt;
      hold_r    <= hold_nxt;
      press_r   <= press_nxt;
      release_r <= release_nxt;
    end
  end

  assign status.press      = press_r;
  assign status.release_ev = release_r;
  assign status.hold       = hold_r;

endmodule

`default_nettype wire

// ----- src/mkdb_merge.sv -----
// ----------------------------------------------------------------------------
// mkdb_merge
// Selects the addressed lane and forms the answer of a query item.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdb_merge
  import mkdb_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire lane_status_t [NUM_KEYS-1:0] lanes,
  input  wire logic [2:0]                  mode,
  input  wire logic [2:0]                  key_index,
  input  wire logic [15:0]                 hold_ms,
  output logic                             answer
);

  lane_status_t sel;
  logic         hit;

  // Pick the addressed lane; an index past the last lane finds nothing.
  always_comb begin
    sel = '0;
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(key_index) == k) begin
        sel = lanes[k];
        hit = 1'b1;
      end
    end
  end

  // Answer by operation.
  always_comb begin
    case (mode)
      MODE_RD_PRESS:   answer = hit & sel.press;
      MODE_RD_RELEASE: answer = hit & sel.release_ev;
      MODE_HOLD_QUERY: answer = hit & (sel.hold >= hold_ms);
      default:         answer = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/multi_key_debouncer_with_events_unit.sv -----
// ----------------------------------------------------------------------------
// multi_key_debouncer_with_events_unit
// Debounces NUM_KEYS switches in parallel lanes and answers flag and hold
// queries through a registered result stage.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Carries
//   in        in_valid / in_ready   in_mode, in_switch_levels, in_key_index,
//                                   in_hold_ms
//   out       out_valid / out_ready out_answer
//   cfg       cfg_wr_en             cfg_wr_data (debounce ticks)
//
// A tick item steps all lanes, and every accepted item loads its answer into
// the output register at the edge where it is accepted, so one item per
// cycle is sustained while out_ready drains the register. in_ready is high
// whenever the output register is empty or is being drained in the same cycle.
// Synchronous reset clears all lanes and loads the debounce register with 20.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debouncer_with_events_unit
  import mkdb_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_switch_levels,
  input  wire logic [2:0]  in_key_index,
  input  wire logic [15:0] in_hold_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_answer,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  logic                        accept;
  logic [7:0]                  debounce_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        answer_r;
  logic                        answer;
  lane_status_t [NUM_KEYS-1:0] status;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Debounce time register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  // One lane per switch.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_ctrl_t ctrl;
    logic       sel;
    logic       level;

    assign sel            = (32'(in_key_index) == k);
    assign ctrl.tick      = accept && (in_mode == MODE_TICK);
    assign ctrl.rd_press  = accept && sel && (in_mode == MODE_RD_PRESS);
    assign ctrl.rd_release = accept && sel && (in_mode == MODE_RD_RELEASE);
    assign ctrl.clr_flags = accept && sel && (in_mode == MODE_CLR_FLAGS);

    // Switches past the level field always see a released level.
    if (k < LEVEL_W) begin : g_lvl
      assign level = in_switch_levels[k];
    end else begin : g_nolvl
      assign level = 1'b0;
    end

    mkdb_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .level          (level),
      .debounce_ticks (debounce_r),
      .status         (status[k])
    );
  end

  // Merge the lanes into the item's answer.
  mkdb_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .lanes     (status),
    .mode      (in_mode),
    .key_index (in_key_index),
    .hold_ms   (in_hold_ms),
    .answer    (answer)
  );

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      answer_r <= answer;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;

endmodule

`default_nettype wire
